// ===== hw/rtl/cdt_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdt_pkg
// Shared types and constants of the dispatch thread id walker.
// ============================================================================
package cdt_pkg;

    // Field widths of the configuration port and of the result word
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_GROUP_W  = 16;
    localparam int CFG_THREAD_W = 11;
    localparam int OUT_GROUP_W  = 16;
    localparam int OUT_LOCAL_W  = 10;
    localparam int OUT_GLOBAL_W = 26;
    localparam int OUT_FLAT_W   = 30;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GROUPS_X  = 3'd0,
        CFG_GROUPS_Y  = 3'd1,
        CFG_GROUPS_Z  = 3'd2,
        CFG_THREADS_X = 3'd3,
        CFG_THREADS_Y = 3'd4,
        CFG_THREADS_Z = 3'd5
    } t_cfg_idx;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIN
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic step;      // input word accepted: advance or restart the walk
        logic mul;       // form the products from the new position
        logic load_out;  // move the finished result into the output register
    } t_cmd;

endpackage

// ===== hw/rtl/cdt_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdt_ctrl
// Sequencer of the walker: input handshake, product step, output register.
// ============================================================================
module cdt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output cdt_pkg::t_cmd o_cmd
);
    import cdt_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_load;

    // output register is free when empty or being drained this cycle
    assign w_load = (r_state == ST_FIN) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_load) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready         = (r_state == ST_IDLE);
        o_cmd.step      = (r_state == ST_IDLE) && i_valid;
        o_cmd.mul       = (r_state == ST_MUL);
        o_cmd.load_out  = w_load;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hw/rtl/cdt_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdt_datapath
// Configuration registers, walk position, products and the result register.
// ============================================================================
module cdt_datapath #(
    parameter int GROUP_BITS  = 16,
    parameter int THREAD_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cdt_pkg::t_cmd                       i_cmd,
    input  logic                                i_restart,
    input  logic                                i_cfg_wr,
    input  logic [cdt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cdt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic [cdt_pkg::OUT_GROUP_W-1:0]     o_group_x,
    output logic [cdt_pkg::OUT_GROUP_W-1:0]     o_group_y,
    output logic [cdt_pkg::OUT_GROUP_W-1:0]     o_group_z,
    output logic [cdt_pkg::OUT_LOCAL_W-1:0]     o_local_x,
    output logic [cdt_pkg::OUT_LOCAL_W-1:0]     o_local_y,
    output logic [cdt_pkg::OUT_LOCAL_W-1:0]     o_local_z,
    output logic [cdt_pkg::OUT_GLOBAL_W-1:0]    o_global_x,
    output logic [cdt_pkg::OUT_GLOBAL_W-1:0]    o_global_y,
    output logic [cdt_pkg::OUT_GLOBAL_W-1:0]    o_global_z,
    output logic [cdt_pkg::OUT_FLAT_W-1:0]      o_flat_index,
    output logic                                o_valid_res,
    output logic                                o_last
);
    import cdt_pkg::*;

    localparam int GCW = GROUP_BITS + 1;
    localparam int TCW = THREAD_BITS + 1;
    localparam int GSW = (GCW > CFG_GROUP_W) ? GCW : CFG_GROUP_W;
    localparam int TSW = (TCW > CFG_THREAD_W) ? TCW : CFG_THREAD_W;
    localparam logic [GSW-1:0] GLIM = GSW'(1) << GROUP_BITS;
    localparam logic [TSW-1:0] TLIM = TSW'(1) << THREAD_BITS;
    localparam int GPW = GROUP_BITS + TCW;
    localparam int LPW = THREAD_BITS + TCW;

    // configuration
    logic [CFG_GROUP_W-1:0]  r_groups_x, r_groups_y, r_groups_z;
    logic [CFG_THREAD_W-1:0] r_threads_x, r_threads_y, r_threads_z;

    // walk position
    logic [THREAD_BITS-1:0] r_lx, r_ly, r_lz, n_lx, n_ly, n_lz;
    logic [GROUP_BITS-1:0]  r_gx, r_gy, r_gz, n_gx, n_gy, n_gz;
    logic                   r_active, n_active;
    logic                   r_emit, n_emit;

    // products
    logic [GPW-1:0] r_pgx, r_pgy, r_pgz;
    logic [LPW-1:0] r_pfz, r_pfy;
    logic           r_last;

    // saturated counts
    logic [GCW-1:0] c_gx, c_gy, c_gz;
    logic [TCW-1:0] c_tx, c_ty, c_tz;
    logic           w_any_zero;
    logic [5:0]     w_inc;
    logic [6:0]     w_carry;

    assign c_gx = GCW'((GSW'(r_groups_x) > GLIM) ? GLIM : GSW'(r_groups_x));
    assign c_gy = GCW'((GSW'(r_groups_y) > GLIM) ? GLIM : GSW'(r_groups_y));
    assign c_gz = GCW'((GSW'(r_groups_z) > GLIM) ? GLIM : GSW'(r_groups_z));
    assign c_tx = TCW'((TSW'(r_threads_x) > TLIM) ? TLIM : TSW'(r_threads_x));
    assign c_ty = TCW'((TSW'(r_threads_y) > TLIM) ? TLIM : TSW'(r_threads_y));
    assign c_tz = TCW'((TSW'(r_threads_z) > TLIM) ? TLIM : TSW'(r_threads_z));

    assign w_any_zero = (c_gx == '0) || (c_gy == '0) || (c_gz == '0) ||
                        (c_tx == '0) || (c_ty == '0) || (c_tz == '0);

    // a coordinate can step when it is below its count minus one
    assign w_inc[0] = (TCW'(r_lx) + TCW'(1)) < c_tx;
    assign w_inc[1] = (TCW'(r_ly) + TCW'(1)) < c_ty;
    assign w_inc[2] = (TCW'(r_lz) + TCW'(1)) < c_tz;
    assign w_inc[3] = (GCW'(r_gx) + GCW'(1)) < c_gx;
    assign w_inc[4] = (GCW'(r_gy) + GCW'(1)) < c_gy;
    assign w_inc[5] = (GCW'(r_gz) + GCW'(1)) < c_gz;

    // carry ripples from local x up to group z
    assign w_carry[0] = 1'b1;
    assign w_carry[1] = w_carry[0] & ~w_inc[0];
    assign w_carry[2] = w_carry[1] & ~w_inc[1];
    assign w_carry[3] = w_carry[2] & ~w_inc[2];
    assign w_carry[4] = w_carry[3] & ~w_inc[3];
    assign w_carry[5] = w_carry[4] & ~w_inc[4];
    assign w_carry[6] = w_carry[5] & ~w_inc[5];

    always_comb begin
        n_lx     = r_lx;
        n_ly     = r_ly;
        n_lz     = r_lz;
        n_gx     = r_gx;
        n_gy     = r_gy;
        n_gz     = r_gz;
        n_active = r_active;
        n_emit   = 1'b0;
        if (i_restart) begin
            n_lx     = '0;
            n_ly     = '0;
            n_lz     = '0;
            n_gx     = '0;
            n_gy     = '0;
            n_gz     = '0;
            n_active = !w_any_zero;
            n_emit   = !w_any_zero;
        end else if (r_active) begin
            if (w_any_zero) begin
                n_active = 1'b0;
            end else begin
                n_lx = w_inc[0] ? r_lx + THREAD_BITS'(1) : '0;
                if (w_carry[1]) n_ly = w_inc[1] ? r_ly + THREAD_BITS'(1) : '0;
                if (w_carry[2]) n_lz = w_inc[2] ? r_lz + THREAD_BITS'(1) : '0;
                if (w_carry[3]) n_gx = w_inc[3] ? r_gx + GROUP_BITS'(1) : '0;
                if (w_carry[4]) n_gy = w_inc[4] ? r_gy + GROUP_BITS'(1) : '0;
                if (w_carry[5]) n_gz = w_inc[5] ? r_gz + GROUP_BITS'(1) : '0;
                // carry out of group z: walk done
                n_active = !w_carry[6];
                n_emit   = !w_carry[6];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups_x  <= CFG_GROUP_W'(1);
            r_groups_y  <= CFG_GROUP_W'(1);
            r_groups_z  <= CFG_GROUP_W'(1);
            r_threads_x <= CFG_THREAD_W'(1);
            r_threads_y <= CFG_THREAD_W'(1);
            r_threads_z <= CFG_THREAD_W'(1);
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_GROUPS_X:  r_groups_x  <= i_cfg_data[CFG_GROUP_W-1:0];
                CFG_GROUPS_Y:  r_groups_y  <= i_cfg_data[CFG_GROUP_W-1:0];
                CFG_GROUPS_Z:  r_groups_z  <= i_cfg_data[CFG_GROUP_W-1:0];
                CFG_THREADS_X: r_threads_x <= i_cfg_data[CFG_THREAD_W-1:0];
                CFG_THREADS_Y: r_threads_y <= i_cfg_data[CFG_THREAD_W-1:0];
                CFG_THREADS_Z: r_threads_z <= i_cfg_data[CFG_THREAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lx     <= '0;
            r_ly     <= '0;
            r_lz     <= '0;
            r_gx     <= '0;
            r_gy     <= '0;
            r_gz     <= '0;
            r_active <= 1'b0;
            r_emit   <= 1'b0;
        end else if (i_cmd.step) begin
            r_lx     <= n_lx;
            r_ly     <= n_ly;
            r_lz     <= n_lz;
            r_gx     <= n_gx;
            r_gy     <= n_gy;
            r_gz     <= n_gz;
            r_active <= n_active;
            r_emit   <= n_emit;
        end
    end

    // first product step: one multiply per lane
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_pgx  <= GPW'(r_gx) * GPW'(c_tx);
            r_pgy  <= GPW'(r_gy) * GPW'(c_ty);
            r_pgz  <= GPW'(r_gz) * GPW'(c_tz);
            r_pfz  <= LPW'(r_lz) * LPW'(c_tx);
            r_pfy  <= LPW'(r_ly) * LPW'(c_tx);
            r_last <= ~|w_inc;
        end
    end

    // result register; a non-emitted word is all zero with last set
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_emit) begin
                o_group_x    <= OUT_GROUP_W'(r_gx);
                o_group_y    <= OUT_GROUP_W'(r_gy);
                o_group_z    <= OUT_GROUP_W'(r_gz);
                o_local_x    <= OUT_LOCAL_W'(r_lx);
                o_local_y    <= OUT_LOCAL_W'(r_ly);
                o_local_z    <= OUT_LOCAL_W'(r_lz);
                o_global_x   <= OUT_GLOBAL_W'(r_pgx) + OUT_GLOBAL_W'(r_lx);
                o_global_y   <= OUT_GLOBAL_W'(r_pgy) + OUT_GLOBAL_W'(r_ly);
                o_global_z   <= OUT_GLOBAL_W'(r_pgz) + OUT_GLOBAL_W'(r_lz);
                o_flat_index <= OUT_FLAT_W'(OUT_FLAT_W'(r_pfz) * OUT_FLAT_W'(c_ty))
                              + OUT_FLAT_W'(r_pfy) + OUT_FLAT_W'(r_lx);
                o_valid_res  <= 1'b1;
                o_last       <= r_last;
            end else begin
                o_group_x    <= '0;
                o_group_y    <= '0;
                o_group_z    <= '0;
                o_local_x    <= '0;
                o_local_y    <= '0;
                o_local_z    <= '0;
                o_global_x   <= '0;
                o_global_y   <= '0;
                o_global_z   <= '0;
                o_flat_index <= '0;
                o_valid_res  <= 1'b0;
                o_last       <= 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/compute_dispatch_thread_ids_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// compute_dispatch_thread_ids_core
// Walks a 3-D compute dispatch one thread per input word and returns the
// group id, thread id, dispatch thread id and flat index of each thread.
// ============================================================================
//
//  channel   handshake                  payload
//  -------   -------------------------  -------------------------------------
//  input     i_valid / o_ready          i_restart
//  result    o_valid / i_ready          o_group_*, o_local_*, o_global_*,
//                                       o_flat_index, o_valid_res, o_last
//  config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  Each input word is accepted and steps the position, then is multiplied,
//  then its result is loaded into the result register.
//  o_ready is high only while no word is in flight; a word whose result waits
//  on a stalled consumer (i_ready low) holds in the load step until taken.
//  A result left in the output register does not block the next input word.
//  Reset (synchronous, active low) sets every count to 1 and stops the walk.
//  Config writes are taken every cycle; indexes beyond the list are ignored.
//
// Walk order: local x fastest, then local y, local z, group x, y, z.
// Counts above 2^THREAD_BITS / 2^GROUP_BITS saturate to those values.
// Any zero count, or advancing past the end, gives a word with valid_res=0,
// last=1 and all other fields zero.
// ============================================================================
module compute_dispatch_thread_ids_core #(
    parameter int GROUP_BITS  = 16,
    parameter int THREAD_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input words
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_restart,
    // result words
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [cdt_pkg::OUT_GROUP_W-1:0]     o_group_x,
    output logic [cdt_pkg::OUT_GROUP_W-1:0]     o_group_y,
    output logic [cdt_pkg::OUT_GROUP_W-1:0]     o_group_z,
    output logic [cdt_pkg::OUT_LOCAL_W-1:0]     o_local_x,
    output logic [cdt_pkg::OUT_LOCAL_W-1:0]     o_local_y,
    output logic [cdt_pkg::OUT_LOCAL_W-1:0]     o_local_z,
    output logic [cdt_pkg::OUT_GLOBAL_W-1:0]    o_global_x,
    output logic [cdt_pkg::OUT_GLOBAL_W-1:0]    o_global_y,
    output logic [cdt_pkg::OUT_GLOBAL_W-1:0]    o_global_z,
    output logic [cdt_pkg::OUT_FLAT_W-1:0]      o_flat_index,
    output logic                                o_valid_res,
    output logic                                o_last,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cdt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cdt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import cdt_pkg::*;

    t_cmd w_cmd;

    // config registers are plain flops: always ready
    assign o_cfg_ready = 1'b1;

    cdt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd)
    );

    cdt_datapath #(
        .GROUP_BITS  (GROUP_BITS),
        .THREAD_BITS (THREAD_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_restart    (i_restart),
        .i_cfg_wr     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_group_x    (o_group_x),
        .o_group_y    (o_group_y),
        .o_group_z    (o_group_z),
        .o_local_x    (o_local_x),
        .o_local_y    (o_local_y),
        .o_local_z    (o_local_z),
        .o_global_x   (o_global_x),
        .o_global_y   (o_global_y),
        .o_global_z   (o_global_z),
        .o_flat_index (o_flat_index),
        .o_valid_res  (o_valid_res),
        .o_last       (o_last)
    );

endmodule
